/* src/sine_bar_backlash_move_planner_core_defines.svh */
// Assertion macros shared by the sine-bar move planner RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SINE_BAR_BACKLASH_MOVE_PLANNER_CORE_DEFINES_SVH
`define SINE_BAR_BACKLASH_MOVE_PLANNER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbbm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbbm assertion failed");

`endif

/* src/sbbm_pkg.sv */
// Types, constants and tables of the sine-bar backlash move planner.
// Depends on nothing; used by every module of the block.
`default_nettype none
package sbbm_pkg;

  localparam int unsigned DVD_W = 60;
  localparam int unsigned DVS_W = 25;
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic [59:0] R_MAX = 60'd4294967296;
  localparam logic [34:0] NEAR_STEPS = 35'd10;

  localparam logic [15:0] RST_GROOVE = 16'd2414;
  localparam logic signed [31:0] RST_SGRAZ = 32'sd1069655906;
  localparam logic signed [32:0] RST_AOFF = 33'sd587130619;
  localparam logic [23:0] RST_LEVER = 24'd8821101;
  localparam logic signed [23:0] RST_LOFF = -24'sd5016344;
  localparam logic signed [20:0] RST_SPM = -21'sd19200;
  localparam logic signed [20:0] RST_BL = 21'sd24000;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS = 2'b01;
  localparam logic [1:0] DIR_NEG = 2'b11;

  // Taylor denominators (2k)(2k+1) and floor(2^34 / denominator).
  localparam logic [8:0] TAYLOR_DEN [8] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
  };
  localparam logic [31:0] TAYLOR_RCP [8] = '{
    32'd2863311530, 32'd858993459, 32'd409044504, 32'd238609294,
    32'd156180628, 32'd110127366, 32'd81808900, 32'd63161283
  };

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REL     = 2'd1,
    ACT_ABS_REL = 2'd2,
    ACT_RANGE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_GROOVE  = 3'd0,
    CFG_SGRAZ   = 3'd1,
    CFG_AOFF    = 3'd2,
    CFG_LEVER   = 3'd3,
    CFG_LOFF    = 3'd4,
    CFG_SPM     = 3'd5,
    CFG_BL      = 3'd6,
    CFG_UNUSED  = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_BIS_CHK, ST_SIN_RED, ST_SIN_SQ, ST_SIN_X2,
    ST_SIN_T1, ST_SIN_T2, ST_SIN_T3, ST_SIN_END, ST_BIS_UPD,
    ST_LEV, ST_LEV2, ST_SPM, ST_SPM2, ST_PLAN, ST_DONE
  } state_e;

  typedef struct packed {
    logic               mode;
    logic [24:0]        target_wavenumber;
    logic signed [31:0] current_position;
  } in_item_t;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] absolute_target;
    logic signed [31:0] relative_steps;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        groove_density;
    logic signed [31:0] sin_grazing;
    logic signed [32:0] angle_offset;
    logic [23:0]        lever_length;
    logic signed [23:0] linear_offset;
    logic signed [20:0] steps_per_mm;
    logic signed [20:0] backlash_steps;
  } cfg_t;

endpackage
`default_nettype wire

/* src/sine_bar_backlash_move_planner_core.sv */
// A target item's result passes through the divider, bisection steps that each evaluate a sine,
// a last sine, then the lever, steps and plan states. A failure item or zero wavenumber skips
// the divider and goes straight to the output state, an out of range quotient once the divider
// is done. Throughput is one item at a time, ready again as the result enters the output
// register. Reset (asynchronous, active low) restores defaults and clears direction.
// Top level of the sine-bar backlash move planner; uses sbbm_pkg, sbbm_cfg, sbbm_div, sbbm_mul.
`default_nettype none
`include "sine_bar_backlash_move_planner_core_defines.svh"
module sine_bar_backlash_move_planner_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sbbm_pkg::in_item_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sbbm_pkg::out_item_t                out_item_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbbm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sbbm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sbbm_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  sbbm_pkg::cfg_t      cfg;
  sbbm_pkg::state_e    state_q, state_d;
  sbbm_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          dir_q, dir_d;
  logic signed [31:0]  cur_q, cur_d;
  logic signed [31:0]  a_q, a_d, lo_q, lo_d, hi_q, hi_d, s_q, s_d;
  logic signed [35:0]  ang_q, ang_d;
  logic [30:0]         u_q, u_d, term_q, term_d;
  logic                neg_q, neg_d, sin_pos_q, sin_pos_d;
  logic [31:0]         x2_q, x2_d;
  logic signed [32:0]  sum_q, sum_d;
  logic [2:0]          k_q, k_d;
  logic [33:0]         pd_q, pd_d;
  logic signed [25:0]  x_q, x_d;
  logic signed [33:0]  tgt_q, tgt_d;

  logic                accept, out_free;
  logic                div_start, div_done;
  logic [59:0]         div_dvd, div_quot;
  logic [33:0]         mul_a;
  logic [31:0]         mul_b;
  logic [65:0]         mul_p;

  logic signed [35:0]  r_ext, a_ext, v0, v1, xf;
  logic signed [32:0]  span, clamp;
  logic signed [31:0]  mid;
  logic [31:0]         q_est, q_fix;
  logic [41:0]         qd, rem;
  logic [24:0]         lev_mag;
  logic [30:0]         spm_mag;
  logic signed [34:0]  delta, ad, abs_t;
  logic [34:0]         ab;

  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == sbbm_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign div_start   = accept && !in_item_i.mode && (in_item_i.target_wavenumber != '0);
  assign div_dvd     = {20'(cfg.groove_density) * 20'd10, 40'd0}
                     + 60'(in_item_i.target_wavenumber >> 1);

  sbbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbbm_div #(
    .DvdW (sbbm_pkg::DVD_W),
    .DvsW (sbbm_pkg::DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (in_item_i.target_wavenumber),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  sbbm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbbm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = div_start ? sbbm_pkg::ST_DIV : sbbm_pkg::ST_DONE;
        end
      end
      sbbm_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (div_quot > sbbm_pkg::R_MAX || a_ext < -36'sd1073741824 ||
                     a_ext > 36'sd1073741824) ? sbbm_pkg::ST_DONE : sbbm_pkg::ST_BIS_CHK;
        end
      end
      sbbm_pkg::ST_BIS_CHK: state_d = sbbm_pkg::ST_SIN_RED;
      sbbm_pkg::ST_SIN_RED: state_d = sbbm_pkg::ST_SIN_SQ;
      sbbm_pkg::ST_SIN_SQ:  state_d = sbbm_pkg::ST_SIN_X2;
      sbbm_pkg::ST_SIN_X2:  state_d = sbbm_pkg::ST_SIN_T1;
      sbbm_pkg::ST_SIN_T1:  state_d = sbbm_pkg::ST_SIN_T2;
      sbbm_pkg::ST_SIN_T2:  state_d = sbbm_pkg::ST_SIN_T3;
      sbbm_pkg::ST_SIN_T3: begin
        state_d = (k_q == 3'd7) ? sbbm_pkg::ST_SIN_END : sbbm_pkg::ST_SIN_T1;
      end
      sbbm_pkg::ST_SIN_END: begin
        state_d = sin_pos_q ? sbbm_pkg::ST_LEV : sbbm_pkg::ST_BIS_UPD;
      end
      sbbm_pkg::ST_BIS_UPD: state_d = sbbm_pkg::ST_BIS_CHK;
      sbbm_pkg::ST_LEV:     state_d = sbbm_pkg::ST_LEV2;
      sbbm_pkg::ST_LEV2:    state_d = sbbm_pkg::ST_SPM;
      sbbm_pkg::ST_SPM:     state_d = sbbm_pkg::ST_SPM2;
      sbbm_pkg::ST_SPM2:    state_d = sbbm_pkg::ST_PLAN;
      sbbm_pkg::ST_PLAN:    state_d = sbbm_pkg::ST_DONE;
      sbbm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sbbm_pkg::ST_IDLE;
        end
      end
      default: state_d = sbbm_pkg::ST_IDLE;
    endcase
  end

  // Shared arithmetic of each step.
  always_comb begin
    r_ext   = signed'(36'(div_quot[32:0]));
    a_ext   = r_ext - 36'(cfg.sin_grazing);
    span    = 33'(hi_q) - 33'(lo_q);
    mid     = lo_q + 32'(span >>> 1);
    v0      = ang_q + sbbm_pkg::PI_Q30;
    v1      = (v0 < 36'sd0) ? v0 + sbbm_pkg::TWO_PI_Q30 :
              (v0 >= sbbm_pkg::TWO_PI_Q30) ? v0 - sbbm_pkg::TWO_PI_Q30 : v0;
    xf      = v1 - sbbm_pkg::PI_Q30;
    if (xf > sbbm_pkg::HALF_PI_Q30) begin
      xf = sbbm_pkg::PI_Q30 - xf;
    end else if (xf < -sbbm_pkg::HALF_PI_Q30) begin
      xf = -sbbm_pkg::PI_Q30 - xf;
    end
    q_est   = mul_p[65:34];
    qd      = 42'(q_est) * 42'(sbbm_pkg::TAYLOR_DEN[k_q]);
    rem     = 42'(pd_q) - qd;
    q_fix   = (rem >= 42'(sbbm_pkg::TAYLOR_DEN[k_q])) ? q_est + 32'd1 : q_est;
    clamp   = (sum_q < 33'sd0) ? 33'sd0 :
              (sum_q > sbbm_pkg::ONE_Q30) ? sbbm_pkg::ONE_Q30 : sum_q;
    lev_mag = 25'((mul_p[54:0] + 55'd536870912) >> 30);
    spm_mag = 31'((mul_p[47:0] + 48'd32768) >> 16);
    delta   = 35'(tgt_q) - 35'(cur_q);
    ad      = (delta < 35'sd0) ? -delta : delta;
    ab      = (cfg.backlash_steps < 21'sd0) ? 35'(-36'(cfg.backlash_steps))
                                             : 35'(cfg.backlash_steps);
    abs_t   = 35'(tgt_q) - 35'(cfg.backlash_steps);
  end

  // Datapath and outputs of each state.
  always_comb begin
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    dir_d       = dir_q;
    cur_d       = cur_q;
    a_d         = a_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    s_d         = s_q;
    ang_d       = ang_q;
    u_d         = u_q;
    neg_d       = neg_q;
    sin_pos_d   = sin_pos_q;
    x2_d        = x2_q;
    term_d      = term_q;
    sum_d       = sum_q;
    k_d         = k_q;
    pd_d        = pd_q;
    x_d         = x_q;
    tgt_d       = tgt_q;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      sbbm_pkg::ST_IDLE: begin
        if (accept) begin
          cur_d = in_item_i.current_position;
          res_d = '{action: sbbm_pkg::ACT_RANGE, absolute_target: '0, relative_steps: '0};
          if (in_item_i.mode) begin
            res_d.action = sbbm_pkg::ACT_NONE;
            dir_d        = sbbm_pkg::DIR_NONE;
          end
        end
      end
      sbbm_pkg::ST_DIV: begin
        a_d  = a_ext[31:0];
        lo_d = -sbbm_pkg::HALF_PI_Q30[31:0];
        hi_d = sbbm_pkg::HALF_PI_Q30[31:0];
      end
      sbbm_pkg::ST_BIS_CHK: begin
        if (span > 33'sd1) begin
          ang_d     = 36'(mid);
          sin_pos_d = 1'b0;
        end else begin
          ang_d     = 36'(cfg.angle_offset) - 36'(lo_q);
          sin_pos_d = 1'b1;
        end
      end
      sbbm_pkg::ST_SIN_RED: begin
        neg_d = xf < 36'sd0;
        u_d   = (xf < 36'sd0) ? 31'(-xf) : 31'(xf);
      end
      sbbm_pkg::ST_SIN_SQ: begin
        mul_a = 34'(u_q);
        mul_b = 32'(u_q);
      end
      sbbm_pkg::ST_SIN_X2: begin
        x2_d   = mul_p[61:30];
        term_d = u_q;
        sum_d  = 33'(u_q);
        k_d    = '0;
      end
      sbbm_pkg::ST_SIN_T1: begin
        mul_a = 34'(term_q);
        mul_b = x2_q;
      end
      sbbm_pkg::ST_SIN_T2: begin
        pd_d  = mul_p[63:30];
        mul_a = mul_p[63:30];
        mul_b = sbbm_pkg::TAYLOR_RCP[k_q];
      end
      sbbm_pkg::ST_SIN_T3: begin
        term_d = q_fix[30:0];
        sum_d  = k_q[0] ? sum_q + 33'(q_fix[30:0]) : sum_q - 33'(q_fix[30:0]);
        k_d    = k_q + 3'd1;
      end
      sbbm_pkg::ST_SIN_END: begin
        s_d = neg_q ? -32'(clamp) : 32'(clamp);
      end
      sbbm_pkg::ST_BIS_UPD: begin
        if (s_q <= a_q) begin
          lo_d = ang_q[31:0];
        end else begin
          hi_d = ang_q[31:0];
        end
      end
      sbbm_pkg::ST_LEV: begin
        mul_a = (s_q < 32'sd0) ? 34'(-33'(s_q)) : 34'(s_q);
        mul_b = 32'(cfg.lever_length);
      end
      sbbm_pkg::ST_LEV2: begin
        x_d = (s_q < 32'sd0) ? 26'(cfg.linear_offset) + 26'(lev_mag)
                             : 26'(cfg.linear_offset) - 26'(lev_mag);
      end
      sbbm_pkg::ST_SPM: begin
        mul_a = (x_q < 26'sd0) ? 34'(-27'(x_q)) : 34'(x_q);
        mul_b = (cfg.steps_per_mm < 21'sd0) ? 32'(-22'(cfg.steps_per_mm))
                                             : 32'(cfg.steps_per_mm);
      end
      sbbm_pkg::ST_SPM2: begin
        tgt_d = ((x_q < 26'sd0) != (cfg.steps_per_mm < 21'sd0)) ? -34'(spm_mag)
                                                                 : 34'(spm_mag);
      end
      sbbm_pkg::ST_PLAN: begin
        if (tgt_q >= -34'sd2147483648 && tgt_q <= 34'sd2147483647) begin
          if (unsigned'(ad) < sbbm_pkg::NEAR_STEPS) begin
            res_d.action = sbbm_pkg::ACT_NONE;
          end else if (dir_q != sbbm_pkg::DIR_NONE &&
                       ((dir_q == sbbm_pkg::DIR_POS) == (delta > 35'sd0)) &&
                       unsigned'(ad) < ab) begin
            res_d.action         = sbbm_pkg::ACT_REL;
            res_d.relative_steps = delta[31:0];
            dir_d = (cfg.backlash_steps > 21'sd0) ? sbbm_pkg::DIR_POS : sbbm_pkg::DIR_NEG;
          end else if (abs_t >= -35'sd2147483648 && abs_t <= 35'sd2147483647) begin
            res_d.action          = sbbm_pkg::ACT_ABS_REL;
            res_d.absolute_target = abs_t[31:0];
            res_d.relative_steps  = 32'(cfg.backlash_steps);
            dir_d = (cfg.backlash_steps > 21'sd0) ? sbbm_pkg::DIR_POS : sbbm_pkg::DIR_NEG;
          end
        end
      end
      sbbm_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbbm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      dir_q       <= sbbm_pkg::DIR_NONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    out_q     <= out_d;
    cur_q     <= cur_d;
    a_q       <= a_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    s_q       <= s_d;
    ang_q     <= ang_d;
    u_q       <= u_d;
    neg_q     <= neg_d;
    sin_pos_q <= sin_pos_d;
    x2_q      <= x2_d;
    term_q    <= term_d;
    sum_q     <= sum_d;
    k_q       <= k_d;
    pd_q      <= pd_d;
    x_q       <= x_d;
    tgt_q     <= tgt_d;
  end

  `SBBM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o)
  `SBBM_ASSERT_IMPLY(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == sbbm_pkg::ST_DIV)
  `SBBM_ASSERT_IMPLY(a_bracket_ordered, clk_i, rst_ni, state_q == sbbm_pkg::ST_BIS_CHK, lo_q < hi_q)

endmodule
`default_nettype wire

/* src/sbbm_cfg.sv */
// Configuration register file of the move planner, written over an APB-style port.
// Depends on sbbm_pkg for the register layout and reset values.
`default_nettype none
module sbbm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbbm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sbbm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sbbm_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output sbbm_pkg::cfg_t                     cfg_o
);

  sbbm_pkg::cfg_t   cfg_q, cfg_d;
  sbbm_pkg::cfg_idx_e idx;
  logic             wr_en;

  assign idx    = sbbm_pkg::cfg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        sbbm_pkg::CFG_GROOVE: cfg_d.groove_density = pwdata[15:0];
        sbbm_pkg::CFG_SGRAZ:  cfg_d.sin_grazing    = pwdata[31:0];
        sbbm_pkg::CFG_AOFF:   cfg_d.angle_offset   = pwdata[32:0];
        sbbm_pkg::CFG_LEVER:  cfg_d.lever_length   = pwdata[23:0];
        sbbm_pkg::CFG_LOFF:   cfg_d.linear_offset  = pwdata[23:0];
        sbbm_pkg::CFG_SPM:    cfg_d.steps_per_mm   = pwdata[20:0];
        sbbm_pkg::CFG_BL:     cfg_d.backlash_steps = pwdata[20:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbbm_pkg::CFG_GROOVE: prdata = 64'(cfg_q.groove_density);
      sbbm_pkg::CFG_SGRAZ:  prdata = 64'(unsigned'(cfg_q.sin_grazing));
      sbbm_pkg::CFG_AOFF:   prdata = 64'(unsigned'(cfg_q.angle_offset));
      sbbm_pkg::CFG_LEVER:  prdata = 64'(cfg_q.lever_length);
      sbbm_pkg::CFG_LOFF:   prdata = 64'(unsigned'(cfg_q.linear_offset));
      sbbm_pkg::CFG_SPM:    prdata = 64'(unsigned'(cfg_q.steps_per_mm));
      sbbm_pkg::CFG_BL:     prdata = 64'(unsigned'(cfg_q.backlash_steps));
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.groove_density <= sbbm_pkg::RST_GROOVE;
      cfg_q.sin_grazing    <= sbbm_pkg::RST_SGRAZ;
      cfg_q.angle_offset   <= sbbm_pkg::RST_AOFF;
      cfg_q.lever_length   <= sbbm_pkg::RST_LEVER;
      cfg_q.linear_offset  <= sbbm_pkg::RST_LOFF;
      cfg_q.steps_per_mm   <= sbbm_pkg::RST_SPM;
      cfg_q.backlash_steps <= sbbm_pkg::RST_BL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

/* src/sbbm_mul.sv */
// Shared unsigned multiplier of the move planner with a registered product.
// Depends on sbbm_pkg for the operand widths.
`default_nettype none
module sbbm_mul (
  input  wire logic                          clk_i,
  input  wire logic [sbbm_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic [sbbm_pkg::MUL_B_W-1:0]  b_i,
  output logic      [sbbm_pkg::MUL_P_W-1:0]  p_o
);

  logic [sbbm_pkg::MUL_P_W-1:0] p_q;

  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= sbbm_pkg::MUL_P_W'(a_i) * sbbm_pkg::MUL_P_W'(b_i);
  end

endmodule
`default_nettype wire

/* src/sbbm_div.sv */
// Restoring divider of the move planner, one quotient bit per cycle.
// Depends on sbbm_pkg for the default operand widths.
`default_nettype none
module sbbm_div #(
  parameter int unsigned DvdW = sbbm_pkg::DVD_W,
  parameter int unsigned DvsW = sbbm_pkg::DVS_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DvdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvdW-1:0] dq_q, dq_d;
  logic [DvsW:0]   rem_sh;
  logic            fits;
  logic            last;

  assign rem_sh = {rem_q, dq_q[DvdW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign last   = cnt_q == CntW'(DvdW - 1);
  assign done_o = done_q;
  assign quot_o = dq_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
      dq_d  = {dq_q[DvdW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

endmodule
`default_nettype wire
